/* rtl/source_token_scanner_defines.svh */
// Assertion macros shared by the scanner checker.
`ifndef SOURCE_TOKEN_SCANNER_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_DEFINES_SVH

// Property checked only while out of reset.
`define STS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define STS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/sts_pkg.sv */
`timescale 1ns / 1ps

package sts_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int RUN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int NUM_CAND      = 4;
    localparam int FIFO_DEPTH    = 4;
    localparam int PTR_W         = $clog2(FIFO_DEPTH);
    localparam int CNT_W         = PTR_W + 1;

    typedef logic [RUN_W-1:0] t_run;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Token kinds
    localparam logic [4:0] K_NEWLINE = 5'd0;
    localparam logic [4:0] K_SEMI    = 5'd1;
    localparam logic [4:0] K_LPAR    = 5'd2;
    localparam logic [4:0] K_RPAR    = 5'd3;
    localparam logic [4:0] K_LBRC    = 5'd4;
    localparam logic [4:0] K_RBRC    = 5'd5;
    localparam logic [4:0] K_COMMA   = 5'd6;
    localparam logic [4:0] K_DOT     = 5'd7;
    localparam logic [4:0] K_MINUS   = 5'd8;
    localparam logic [4:0] K_PLUS    = 5'd9;
    localparam logic [4:0] K_STAR    = 5'd10;
    localparam logic [4:0] K_BANG    = 5'd11;
    localparam logic [4:0] K_BANG_EQ = 5'd12;
    localparam logic [4:0] K_EQ      = 5'd13;
    localparam logic [4:0] K_EQ_EQ   = 5'd14;
    localparam logic [4:0] K_IDENT   = 5'd15;
    localparam logic [4:0] K_NUMBER  = 5'd16;
    localparam logic [4:0] K_UNKNOWN = 5'd17;
    localparam logic [4:0] K_END     = 5'd18;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_IDENT = 5'b00010,
        MODE_NUM   = 5'b00100,
        MODE_BANG  = 5'b01000,
        MODE_EQ    = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_sts_in;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [7:0]  token_length;
        logic [15:0] line_number;
        logic        last_result;
    } t_sts_out;

    typedef struct packed {
        t_mode       mode;
        t_run        run_length;
        logic [15:0] line_count;
    } t_sts_state;

endpackage

/* rtl/sts_lexer.sv */
`timescale 1ns / 1ps

module sts_lexer import sts_pkg::*; (
    input  t_sts_in                   i_item,
    input  t_sts_state                i_state,
    output t_sts_state                o_state,
    output t_sts_out [NUM_CAND-1:0]   o_tok,
    output logic     [NUM_CAND-1:0]   o_tok_valid
);

    function automatic logic [7:0] clamp_len(t_run run);
        logic [RUN_W+7:0] wide;
        wide = (RUN_W + 8)'(run);
        if (wide > (RUN_W + 8)'(255)) begin
            return 8'hFF;
        end
        return wide[7:0];
    endfunction

    function automatic t_run grow(t_run run);
        if (run < RUN_W'(MAX_TOKEN_LEN)) begin
            return run + RUN_W'(1);
        end
        return run;
    endfunction

    // Token for whatever is pending in the given mode; valid low when nothing is.
    function automatic logic [$bits(t_sts_out):0] flush_tok(t_mode m, t_run run,
                                                           logic [15:0] line);
        t_sts_out t;
        logic     v;
        t.token_kind   = K_UNKNOWN;
        t.token_length = 8'd1;
        t.line_number  = line;
        t.last_result  = 1'b0;
        v = 1'b1;
        case (m)
            MODE_IDENT: begin
                t.token_kind   = K_IDENT;
                t.token_length = clamp_len(run);
            end
            MODE_NUM: begin
                t.token_kind   = K_NUMBER;
                t.token_length = clamp_len(run);
            end
            MODE_BANG: t.token_kind = K_BANG;
            MODE_EQ:   t.token_kind = K_EQ;
            default:   v = 1'b0;
        endcase
        return {v, t};
    endfunction

    logic        is_letter;
    logic        is_digit;
    logic        consumed;
    t_mode       mode1;
    t_mode       mode2;
    t_run        run1;
    t_run        run2;
    logic [15:0] line2;
    t_sts_out    tk [NUM_CAND];
    logic [NUM_CAND-1:0] tv;

    always_comb begin
        is_letter = i_item.ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
        is_digit  = i_item.ch inside {[8'h30:8'h39]};

        for (int i = 0; i < NUM_CAND; i++) begin
            tk[i].token_kind   = K_END;
            tk[i].token_length = 8'd1;
            tk[i].line_number  = i_state.line_count;
            tk[i].last_result  = 1'b0;
        end
        tv = '0;

        // Extend or close the pending token
        consumed = 1'b1;
        mode1    = i_state.mode;
        run1     = i_state.run_length;
        if (i_state.mode == MODE_IDENT && is_letter) begin
            run1 = grow(i_state.run_length);
        end else if (i_state.mode == MODE_NUM && is_digit) begin
            run1 = grow(i_state.run_length);
        end else if (i_state.mode == MODE_BANG && i_item.ch == CH_EQ) begin
            tv[0] = 1'b1;
            tk[0].token_kind   = K_BANG_EQ;
            tk[0].token_length = 8'd2;
            mode1 = MODE_IDLE;
        end else if (i_state.mode == MODE_EQ && i_item.ch == CH_EQ) begin
            tv[0] = 1'b1;
            tk[0].token_kind   = K_EQ_EQ;
            tk[0].token_length = 8'd2;
            mode1 = MODE_IDLE;
        end else begin
            consumed = 1'b0;
            {tv[0], tk[0]} = flush_tok(i_state.mode, i_state.run_length,
                                       i_state.line_count);
            mode1 = MODE_IDLE;
            run1  = '0;
        end

        // Scan the byte as the start of a new token
        mode2 = mode1;
        run2  = run1;
        line2 = i_state.line_count;
        if (!consumed) begin
            tv[1] = 1'b1;
            case (i_item.ch)
                CH_SPACE: tv[1] = 1'b0;
                CH_NL: begin
                    tk[1].token_kind = K_NEWLINE;
                    if (i_state.line_count != 16'hFFFF) begin
                        line2 = i_state.line_count + 16'd1;
                    end
                end
                CH_SEMI:  tk[1].token_kind = K_SEMI;
                CH_LPAR:  tk[1].token_kind = K_LPAR;
                CH_RPAR:  tk[1].token_kind = K_RPAR;
                CH_LBRC:  tk[1].token_kind = K_LBRC;
                CH_RBRC:  tk[1].token_kind = K_RBRC;
                CH_COMMA: tk[1].token_kind = K_COMMA;
                CH_DOT:   tk[1].token_kind = K_DOT;
                CH_MINUS: tk[1].token_kind = K_MINUS;
                CH_PLUS:  tk[1].token_kind = K_PLUS;
                CH_STAR:  tk[1].token_kind = K_STAR;
                CH_BANG: begin
                    tv[1] = 1'b0;
                    mode2 = MODE_BANG;
                end
                CH_EQ: begin
                    tv[1] = 1'b0;
                    mode2 = MODE_EQ;
                end
                default: begin
                    if (is_letter) begin
                        tv[1] = 1'b0;
                        mode2 = MODE_IDENT;
                        run2  = RUN_W'(1);
                    end else if (is_digit) begin
                        tv[1] = 1'b0;
                        mode2 = MODE_NUM;
                        run2  = RUN_W'(1);
                    end else begin
                        tk[1].token_kind = K_UNKNOWN;
                    end
                end
            endcase
        end

        // Last byte: flush, then the end token, then drop back to reset state
        o_state.mode       = mode2;
        o_state.run_length = run2;
        o_state.line_count = line2;
        if (i_item.end_of_text) begin
            {tv[2], tk[2]} = flush_tok(mode2, run2, line2);
            tv[3] = 1'b1;
            tk[3].token_kind   = K_END;
            tk[3].token_length = 8'd0;
            tk[3].line_number  = line2;
            o_state.mode       = MODE_IDLE;
            o_state.run_length = '0;
            o_state.line_count = 16'd1;
        end

        for (int i = 0; i < NUM_CAND; i++) begin
            tk[i].last_result = tv[i] && ((tv >> (i + 1)) == '0);
            o_tok[i] = tk[i];
        end
        o_tok_valid = tv;
    end

endmodule

/* rtl/source_token_scanner.sv */
`timescale 1ns / 1ps

// Byte-stream lexical scanner.
// Input channel (i_in_valid / o_in_ready / i_in_data): one source byte per
// request, with end_of_text set on the final byte of a text.
// Output channel (o_out_valid / i_out_ready / o_out_data): one token per
// request carrying kind, length, line number and a flag on the last token
// caused by a byte. A byte yields zero to three tokens.
// Timing: a byte is held in the input register while the lexer scans it, and
// its tokens are written to a four-entry output buffer when that register
// advances; the first token is offered from the buffer after that write.
// Throughput: one byte per cycle while tokens leave at least as fast as they
// are made. The input register advances only when the output buffer has
// room for all tokens of its byte, so a byte giving two or three tokens
// holds the input only while the buffer lacks room for them.
// A stalled receiver fills the buffer; o_in_ready then goes low whenever the
// held byte's tokens do not fit, and nothing is dropped.
// Reset empties both registers and returns to idle scanning on line one.

module source_token_scanner import sts_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_sts_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_sts_out o_out_data
);

    logic       r_in_valid;
    t_sts_in    r_in;
    t_sts_state r_state;
    t_sts_state n_state;

    t_sts_out   r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    t_sts_out [NUM_CAND-1:0] tok;
    logic     [NUM_CAND-1:0] tok_valid;
    logic [PTR_W-1:0] wr_idx [NUM_CAND];
    logic [CNT_W-1:0] ntok;
    logic [CNT_W:0]   fill_after;
    logic             pop;
    logic             adv;

    sts_lexer u_lexer (
        .i_item      (r_in),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_tok       (tok),
        .o_tok_valid (tok_valid)
    );

    // Pack the valid tokens into consecutive buffer slots
    always_comb begin
        ntok = '0;
        for (int i = 0; i < NUM_CAND; i++) begin
            wr_idx[i] = r_wptr + PTR_W'(ntok);
            ntok = ntok + CNT_W'(tok_valid[i]);
        end
    end

    assign pop         = (r_count != '0) && i_out_ready;
    assign fill_after  = (CNT_W + 1)'(r_count) - (CNT_W + 1)'(pop) + (CNT_W + 1)'(ntok);
    assign adv         = r_in_valid && (fill_after <= (CNT_W + 1)'(FIFO_DEPTH));
    assign o_in_ready  = !r_in_valid || adv;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_state.mode       <= MODE_IDLE;
            r_state.run_length <= '0;
            r_state.line_count <= 16'd1;
            r_wptr             <= '0;
            r_rptr             <= '0;
            r_count            <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_state <= n_state;
                r_wptr  <= r_wptr + PTR_W'(ntok);
            end
            if (pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_count <= r_count - CNT_W'(pop) + (adv ? ntok : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            for (int i = 0; i < NUM_CAND; i++) begin
                if (tok_valid[i]) begin
                    r_fifo[wr_idx[i]] <= tok[i];
                end
            end
        end
    end

endmodule

/* rtl/sts_checker.sv */
`timescale 1ns / 1ps
`include "source_token_scanner_defines.svh"

module sts_checker import sts_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_sts_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_sts_out o_out_data
);

    logic in_stall;
    logic out_stall;
    logic end_tok;
    logic end_ok;
    logic mid_tok;
    logic mid_ok;

    assign in_stall  = i_in_valid && !o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign end_tok   = o_out_valid && o_out_data.token_kind == K_END;
    assign end_ok    = o_out_data.token_length == 8'd0 && o_out_data.last_result;
    assign mid_tok   = o_out_valid && o_out_data.token_kind != K_END;
    assign mid_ok    = o_out_data.token_length != 8'd0 && o_out_data.line_number != 16'd0;

    // Buffer and input register come out of reset empty
    `STS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid && o_in_ready, "busy after reset")

    // Hold a waiting request
    `STS_ASSERT(a_in_hold, in_stall |=> i_in_valid && $stable(i_in_data), "request not held")

    // Hold a stalled token
    `STS_ASSERT(a_out_hold, out_stall |=> o_out_valid && $stable(o_out_data), "token not held")

    // End token closes the byte's results and has no characters
    `STS_ASSERT(a_end_token, end_tok |-> end_ok, "malformed end token")

    // Only the end token is empty, and lines count from one
    `STS_ASSERT(a_token_fields, mid_tok |-> mid_ok, "bad token fields")

endmodule

bind source_token_scanner sts_checker u_sts_checker (.*);

/* tb/sv/tb_source_token_scanner.sv */
`timescale 1ns / 1ps

module tb_source_token_scanner;
    import sts_pkg::*;

    // Tracks the scanner state and the tokens still owed by the block.
    class expected_tokens;
        t_mode       mode    = MODE_IDLE;
        t_run        run_len = '0;
        logic [15:0] line_no = 16'd1;
        t_sts_out    token_q[$];
        int          n_errors = 0;

        function bit is_letter(logic [7:0] c);
            return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function void push_token(logic [4:0] kind, int unsigned len);
            t_sts_out t;
            t.token_kind   = kind;
            t.token_length = (len > 255) ? 8'd255 : len[7:0];
            t.line_number  = line_no;
            t.last_result  = 1'b0;
            token_q.push_back(t);
        endfunction

        function void grow_run();
            if (run_len < MAX_TOKEN_LEN)
                run_len++;
        endfunction

        function void close_pending();
            case (mode)
                MODE_IDENT: push_token(K_IDENT, run_len);
                MODE_NUM:   push_token(K_NUMBER, run_len);
                MODE_BANG:  push_token(K_BANG, 1);
                MODE_EQ:    push_token(K_EQ, 1);
                default: ;
            endcase
            mode    = MODE_IDLE;
            run_len = '0;
        endfunction

        function void scan_fresh(logic [7:0] c);
            case (c)
                CH_SPACE: ;
                CH_NL: begin
                    push_token(K_NEWLINE, 1);
                    if (line_no != 16'hFFFF)
                        line_no++;
                end
                CH_SEMI:  push_token(K_SEMI, 1);
                CH_LPAR:  push_token(K_LPAR, 1);
                CH_RPAR:  push_token(K_RPAR, 1);
                CH_LBRC:  push_token(K_LBRC, 1);
                CH_RBRC:  push_token(K_RBRC, 1);
                CH_COMMA: push_token(K_COMMA, 1);
                CH_DOT:   push_token(K_DOT, 1);
                CH_MINUS: push_token(K_MINUS, 1);
                CH_PLUS:  push_token(K_PLUS, 1);
                CH_STAR:  push_token(K_STAR, 1);
                CH_BANG:  mode = MODE_BANG;
                CH_EQ:    mode = MODE_EQ;
                default: begin
                    if (is_letter(c)) begin
                        mode    = MODE_IDENT;
                        run_len = 1;
                    end else if (is_digit(c)) begin
                        mode    = MODE_NUM;
                        run_len = 1;
                    end else begin
                        push_token(K_UNKNOWN, 1);
                    end
                end
            endcase
        endfunction

        function void note_byte(t_sts_in req);
            int       n0;
            t_sts_out t;
            n0 = token_q.size();
            if (mode == MODE_IDENT && is_letter(req.ch)) begin
                grow_run();
            end else if (mode == MODE_NUM && is_digit(req.ch)) begin
                grow_run();
            end else if (mode == MODE_BANG && req.ch == CH_EQ) begin
                push_token(K_BANG_EQ, 2);
                mode = MODE_IDLE;
            end else if (mode == MODE_EQ && req.ch == CH_EQ) begin
                push_token(K_EQ_EQ, 2);
                mode = MODE_IDLE;
            end else begin
                // the byte ends whatever was pending, then starts fresh
                close_pending();
                scan_fresh(req.ch);
            end
            if (req.end_of_text) begin
                close_pending();
                push_token(K_END, 0);
                line_no = 16'd1;
            end
            if (token_q.size() > n0) begin
                t = token_q.pop_back();
                t.last_result = 1'b1;
                token_q.push_back(t);
            end
        endfunction

        function void check_token(t_sts_out got);
            t_sts_out exp;
            if (token_q.size() == 0) begin
                $display("%0t: unexpected token kind %0d len %0d line %0d last %0b",
                         $time, got.token_kind, got.token_length, got.line_number,
                         got.last_result);
                n_errors++;
                return;
            end
            exp = token_q.pop_front();
            if (got.token_kind !== exp.token_kind || got.token_length !== exp.token_length ||
                got.line_number !== exp.line_number || got.last_result !== exp.last_result) begin
                $display("%0t: token mismatch: expected kind %0d len %0d line %0d last %0b,",
                         $time, exp.token_kind, exp.token_length, exp.line_number,
                         exp.last_result,
                         " got kind %0d len %0d line %0d last %0b",
                         got.token_kind, got.token_length, got.line_number,
                         got.last_result);
                n_errors++;
            end
        endfunction

        function int pending();
            return token_q.size();
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_sts_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_sts_out o_out_data;

    expected_tokens tokens = new;
    int             idle_pct  = 20;
    int             stall_pct = 83;
    logic [7:0]     text_q[$];

    source_token_scanner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tokens.check_token(o_out_data);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task send_byte(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{ch: c, end_of_text: eot};
        do @(posedge i_clk); while (!o_in_ready);
        tokens.note_byte(i_in_data);
        @(negedge i_clk);
    endtask

    task add_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Flag the final byte of the text as its end.
    task send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task build_random_text();
        int         n_tok;
        int         n;
        string      punct;
        logic [7:0] b;
        punct = ";(){},.-+*";
        n_tok = $urandom_range(12, 1);
        if ($urandom_range(7) == 0) begin
            // raw noise
            repeat (n_tok) text_q.push_back(8'($urandom_range(255)));
            return;
        end
        repeat (n_tok) begin
            case ($urandom_range(9))
                0, 1: begin
                    n = $urandom_range(6, 1);
                    repeat (n) begin
                        b = $urandom_range(1) ? 8'h61 : 8'h41;
                        text_q.push_back(8'(b + $urandom_range(25)));
                    end
                end
                2: begin
                    n = $urandom_range(5, 1);
                    repeat (n) text_q.push_back(8'(8'h30 + $urandom_range(9)));
                end
                3: text_q.push_back(punct[$urandom_range(punct.len() - 1)]);
                4: begin
                    text_q.push_back(CH_BANG);
                    if ($urandom_range(1)) text_q.push_back(CH_EQ);
                end
                5: begin
                    text_q.push_back(CH_EQ);
                    if ($urandom_range(1)) text_q.push_back(CH_EQ);
                end
                6: repeat ($urandom_range(3, 1)) text_q.push_back(CH_SPACE);
                7: text_q.push_back(CH_NL);
                default: text_q.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    task send_random_texts(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_random_text();
            sent += text_q.size();
            send_text();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // letters and digits at their limits, every operator, pending '=' at the end
        add_string("zA 90!=!q==\n;(){},.-+*=");
        send_text();
        // unknown bytes at both extremes around a lone '='
        text_q.push_back(8'h00);
        text_q.push_back(CH_EQ);
        text_q.push_back(8'hFF);
        send_text();
        add_string("!");
        send_text();

        send_random_texts(50);
        idle_pct  = 83;
        stall_pct = 20;
        send_random_texts(50);
        idle_pct  = 0;
        stall_pct = 0;
        send_random_texts(50);

        // run past the length limit
        repeat (258) text_q.push_back(8'(8'h61 + $urandom_range(25)));
        add_string(";");
        send_text();

        i_in_valid <= 1'b0;
        while (tokens.pending() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (tokens.pending() != 0)
            $display("%0t: %0d expected tokens never arrived", $time, tokens.pending());
        if (tokens.n_errors == 0 && tokens.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sts_pkg.sv
rtl/sts_lexer.sv
rtl/source_token_scanner.sv
rtl/sts_checker.sv
tb/sv/tb_source_token_scanner.sv
